[rtl/core/uart_baud_divisor_calc_macros.svh]
// Assertion macros shared by the baud divisor checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef UART_BAUD_DIVISOR_CALC_MACROS_SVH
`define UART_BAUD_DIVISOR_CALC_MACROS_SVH

// Same-cycle implication, masked while reset is high
`define UBDC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ubdc: implication check failed");

// Next-cycle implication, masked while reset is high
`define UBDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ubdc: next-cycle check failed");

`endif

[rtl/core/ubdc_pkg.sv]
// Types and constants for the UART baud divisor calculator.
// No dependencies; imported by every module of the block.
package ubdc_pkg;

  // Field widths
  localparam int unsigned PORT_W   = 3;
  localparam int unsigned BAUD_W   = 32;
  localparam int unsigned CLK_W    = 28;
  localparam int unsigned FB_W     = 26;
  localparam int unsigned DIV_W    = 13;
  localparam int unsigned FINE_W   = 5;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = CLK_W;

  // Divider widths: numerator is 2*clock, divisor is the effective baud
  localparam int unsigned NUM_W = CLK_W + 1;
  localparam int unsigned DEN_W = CLK_W - 1;
  localparam int unsigned QUO_W = DIV_W + FINE_W;
  localparam int unsigned NCELL = NUM_W;

  // Register reset values
  localparam logic [CLK_W-1:0] BASE_CLOCK_RESET = CLK_W'(100000000);
  localparam logic [FB_W-1:0]  FALLBACK_RESET   = FB_W'(1000);

  // Highest port number that runs from the full clock
  localparam logic [PORT_W-1:0] LAST_FULL_PORT = PORT_W'(1);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_CLOCK    = 1'b0,
    CFG_FALLBACK_BAUD = 1'b1
  } cfg_idx_t;

  // Work item handed along the divider row
  typedef struct packed {
    logic             zero;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [QUO_W-1:0] quo;
  } ubdc_work_t;

endpackage

[rtl/core/ubdc_front.sv]
// Front stage: configuration registers, clock and baud selection.
// Depends on ubdc_pkg; feeds the first divider cell.
module ubdc_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ubdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ubdc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           up_valid,
  output logic                           up_ready,
  input  logic [ubdc_pkg::PORT_W-1:0]    port_number,
  input  logic [ubdc_pkg::BAUD_W-1:0]    baud_request,
  output logic                           down_valid,
  input  logic                           down_ready,
  output ubdc_pkg::ubdc_work_t            down_data
);
  import ubdc_pkg::*;

  logic [CLK_W-1:0] base_clock_hz;
  logic [FB_W-1:0]  fallback_baud;
  logic             valid;
  ubdc_work_t       work;
  ubdc_work_t       work_next;
  logic [DEN_W-1:0] half_clk;
  logic [CLK_W-1:0] port_clk;
  logic             use_fallback;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_clock_hz <= BASE_CLOCK_RESET;
      fallback_baud <= FALLBACK_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BASE_CLOCK:    base_clock_hz <= cfg_data[CLK_W-1:0];
        CFG_FALLBACK_BAUD: fallback_baud <= cfg_data[FB_W-1:0];
        default: ;
      endcase
    end
  end

  // Port clock, limit test and effective baud
  always_comb begin
    half_clk     = base_clock_hz[CLK_W-1:1];
    port_clk     = (port_number <= LAST_FULL_PORT) ? base_clock_hz : {1'b0, half_clk};
    use_fallback = (baud_request == '0) ||
                   (baud_request > {{(BAUD_W-DEN_W){1'b0}}, half_clk});
    work_next.num  = {port_clk, 1'b0};
    work_next.rem  = '0;
    work_next.quo  = '0;
    work_next.den  = use_fallback ? {{(DEN_W-FB_W){1'b0}}, fallback_baud}
                                  : baud_request[DEN_W-1:0];
    work_next.zero = (work_next.den == '0);
  end

  assign up_ready = !valid || down_ready;

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      work <= work_next;
    end
  end

  assign down_valid = valid;
  assign down_data  = work;

endmodule

[rtl/core/ubdc_cell.sv]
// One restoring-division cell: brings down one numerator bit per request.
// Depends on ubdc_pkg; instanced in a row by the top level.
module ubdc_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  ubdc_pkg::ubdc_work_t  up_data,
  output logic                 down_valid,
  input  logic                 down_ready,
  output ubdc_pkg::ubdc_work_t  down_data
);
  import ubdc_pkg::*;

  logic             valid;
  ubdc_work_t       work;
  ubdc_work_t       work_next;
  logic [DEN_W:0]   trial;
  logic [DEN_W+1:0] diff;
  logic             fits;

  // Shift in the next numerator bit and try a subtract
  always_comb begin
    trial = {up_data.rem, up_data.num[NUM_W-1]};
    diff  = {1'b0, trial} - {2'b00, up_data.den};
    fits  = !diff[DEN_W+1];
    work_next      = up_data;
    work_next.num  = {up_data.num[NUM_W-2:0], 1'b0};
    work_next.rem  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    work_next.quo  = {up_data.quo[QUO_W-2:0], fits};
  end

  // Accept whenever the cell is empty or its contents move on
  assign up_ready = !valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      work <= work_next;
    end
  end

  assign down_valid = valid;
  assign down_data  = work;

endmodule

[rtl/core/uart_baud_divisor_calc.sv]
// Top level of the UART baud divisor calculator.
// Depends on ubdc_pkg, ubdc_front and ubdc_cell.
//
//   channel   signals                               direction
//   config    cfg_valid/cfg_ready, cfg_index/data   in
//   request   in_valid/in_stall, port_number/baud   in
//   result    out_valid/out_stall, divisor/fine     out
//
// One request a cycle while in_stall is low; the row is the front stage plus 29
// division cells, one quotient bit of floor(2*clock/baud) per cell.
// Reset clears every stage valid and restores both configuration registers.
// A stalled result holds in the last cell; stages behind it keep filling
// empty slots and in_stall rises only when the row is full up to the front.
module uart_baud_divisor_calc (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ubdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ubdc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ubdc_pkg::PORT_W-1:0]    port_number,
  input  logic [ubdc_pkg::BAUD_W-1:0]    baud_request,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ubdc_pkg::DIV_W-1:0]     divisor,
  output logic [ubdc_pkg::FINE_W-1:0]    fine_adjust
);
  import ubdc_pkg::*;

  logic [NCELL:0] link_valid;
  logic [NCELL:0] link_ready;
  ubdc_work_t     link_data [NCELL+1];
  logic           front_ready;

  ubdc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .up_valid    (in_valid),
    .up_ready    (front_ready),
    .port_number (port_number),
    .baud_request(baud_request),
    .down_valid  (link_valid[0]),
    .down_ready  (link_ready[0]),
    .down_data   (link_data[0])
  );

  assign in_stall = !front_ready;

  // Row of division cells, most significant quotient bit first
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    ubdc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .up_valid  (link_valid[i]),
      .up_ready  (link_ready[i]),
      .up_data   (link_data[i]),
      .down_valid(link_valid[i+1]),
      .down_ready(link_ready[i+1]),
      .down_data (link_data[i+1])
    );
  end

  assign link_ready[NCELL] = !out_stall;
  assign out_valid         = link_valid[NCELL];

  // Split the low quotient bits; a zero baud gives zero results
  assign divisor     = link_data[NCELL].zero ? '0 : link_data[NCELL].quo[QUO_W-1:FINE_W];
  assign fine_adjust = link_data[NCELL].zero ? '0 : link_data[NCELL].quo[FINE_W-1:0];

endmodule

[rtl/core/ubdc_checker.sv]
// Port-level checks for the UART baud divisor calculator, bound to the top.
// Depends on ubdc_pkg and uart_baud_divisor_calc_macros.svh.
`include "uart_baud_divisor_calc_macros.svh"

module ubdc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [ubdc_pkg::DIV_W-1:0]     divisor,
  input logic [ubdc_pkg::FINE_W-1:0]    fine_adjust
);
  import ubdc_pkg::*;

  // A stalled result stays put
  `UBDC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
                    out_valid && $stable(divisor) && $stable(fine_adjust))

  // With the result side open the whole row moves, so requests flow in
  `UBDC_ASSERT_IMPLY(a_flow_through, clk, rst, !out_stall, !in_stall)

  // Configuration writes are never held off
  `UBDC_ASSERT_IMPLY(a_cfg_open, clk, rst, cfg_valid, cfg_ready)

  // The row comes out of reset empty
  `UBDC_ASSERT_IMPLY(a_reset_empty, clk, rst, $fell(rst), !out_valid && !in_stall)

endmodule

bind uart_baud_divisor_calc ubdc_checker u_ubdc_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for uart_baud_divisor_calc: a directed table, then random
// request phases under several register settings. Depends on ubdc_pkg and the block's RTL.
module testbench;
  import ubdc_pkg::*;

  localparam int unsigned PIPE_DEPTH  = 30;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [DIV_W-1:0]  div;
    logic [FINE_W-1:0] fine;
  } rate_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    cfg_idx_t              idx;
    logic [CFG_DATA_W-1:0] data;
    logic [PORT_W-1:0]     port;
    logic [BAUD_W-1:0]     baud;
    logic                  typed;
    rate_t                 want;
  } dir_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [PORT_W-1:0]     port_number;
  logic [BAUD_W-1:0]     baud_request;
  logic                  out_valid;
  logic                  out_stall;
  logic [DIV_W-1:0]      divisor;
  logic [FINE_W-1:0]     fine_adjust;

  // Shadow copies of the two registers
  logic [CLK_W-1:0] clock_hz      = BASE_CLOCK_RESET;
  logic [FB_W-1:0]  fallback_rate = FALLBACK_RESET;

  rate_t    rate_q[$];
  int       mismatches  = 0;
  int       idle_odds   = 4;
  bit       quiet       = 1'b0;
  bit       sender_gaps = 1'b1;
  bit       hold_now    = 1'b0;
  dir_row_t dir_tab [31];

  uart_baud_divisor_calc u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .port_number (port_number),
    .baud_request(baud_request),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .divisor     (divisor),
    .fine_adjust (fine_adjust)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Divisor and fine adjust are the two slices of floor(2*clock/baud)
  function automatic rate_t predict_rate(logic [PORT_W-1:0] port, logic [BAUD_W-1:0] req);
    logic [63:0] limit;
    logic [63:0] port_clk;
    logic [63:0] eff;
    logic [63:0] q;
    rate_t       r;
    limit    = 64'(clock_hz) >> 1;
    port_clk = (port <= LAST_FULL_PORT) ? 64'(clock_hz) : limit;
    eff      = (req == '0 || 64'(req) > limit) ? 64'(fallback_rate) : 64'(req);
    q        = (eff == 64'd0) ? 64'd0 : (port_clk << 1) / eff;
    r.div    = q[FINE_W +: DIV_W];
    r.fine   = q[FINE_W-1:0];
    return r;
  endfunction

  function automatic dir_row_t req_row(logic [PORT_W-1:0] p, logic [BAUD_W-1:0] b);
    dir_row_t r;
    r       = '0;
    r.kind  = ROW_REQ;
    r.port  = p;
    r.baud  = b;
    return r;
  endfunction

  function automatic dir_row_t lit_row(logic [PORT_W-1:0] p, logic [BAUD_W-1:0] b,
                                       logic [DIV_W-1:0] d, logic [FINE_W-1:0] f);
    dir_row_t r;
    r           = req_row(p, b);
    r.typed     = 1'b1;
    r.want.div  = d;
    r.want.fine = f;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
    dir_row_t r;
    r      = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.data = v;
    return r;
  endfunction

  // Register write; valid is left high and dropped by whoever drives next
  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_BASE_CLOCK) clock_hz = data[CLK_W-1:0];
    else fallback_rate = data[FB_W-1:0];
  endtask

  // Offer one request and hold it until taken, then maybe go quiet a while
  task automatic send_request(logic [PORT_W-1:0] port, logic [BAUD_W-1:0] req,
                              logic typed, rate_t want);
    if (cfg_valid) cfg_valid <= 1'b0;
    in_valid     <= 1'b1;
    port_number  <= port;
    baud_request <= req;
    do @(posedge clk); while (in_stall);
    rate_q.push_back(typed ? want : predict_rate(port, req));
    if (!quiet && sender_gaps && $urandom_range(1, idle_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Block is idle once every issued request has its result back
  task automatic wait_idle();
    if (in_valid) in_valid <= 1'b0;
    wait (rate_q.size() == 0);
  endtask

  task automatic pick_setting();
    logic [CFG_DATA_W-1:0] v;
    int                    which;
    which = $urandom_range(0, 2);
    wait_idle();
    if (which != 1) begin
      case ($urandom_range(0, 4))
        0:       v = CFG_DATA_W'(BASE_CLOCK_RESET);
        1:       v = CFG_DATA_W'($urandom);
        2:       v = CFG_DATA_W'($urandom_range(1, 2000));
        3:       v = '1;
        default: v = CFG_DATA_W'($urandom_range(1_000_000, 200_000_000));
      endcase
      write_reg(CFG_BASE_CLOCK, v);
    end
    if (which != 0) begin
      case ($urandom_range(0, 5))
        0:       v = CFG_DATA_W'($urandom);
        1:       v = CFG_DATA_W'($urandom_range(1, 100));
        2:       v = CFG_DATA_W'($urandom_range(300, 1_000_000));
        3:       v = CFG_DATA_W'({FB_W{1'b1}});
        4:       v = '0;
        default: v = CFG_DATA_W'(FALLBACK_RESET);
      endcase
      write_reg(CFG_FALLBACK_BAUD, v);
    end
  endtask

  // Random requests, mostly inside the accepted range of the current clock
  task automatic run_phase(int count);
    logic [BAUD_W-1:0] req;
    logic [63:0]       limit;
    for (int n = 0; n < count; n++) begin
      limit = 64'(clock_hz) >> 1;
      case ($urandom_range(0, 9))
        0:       req = '0;
        1:       req = BAUD_W'($urandom);
        2:       req = BAUD_W'(limit) + BAUD_W'($urandom_range(0, 2)) - BAUD_W'(1);
        3, 4, 5: req = BAUD_W'(64'd1 + 64'($urandom) % ((limit > 0) ? limit : 64'd1));
        default: req = BAUD_W'($urandom_range(1, 1 << $urandom_range(0, 17)));
      endcase
      send_request(PORT_W'($urandom_range(0, 7)), req, 1'b0, '0);
    end
  endtask

  // Receiver: short random stalls, or one long hold when asked
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_now) begin
        hold_now = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(1, idle_odds) == 1) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Score each result against the oldest outstanding request
  always @(posedge clk) begin
    rate_t want;
    if (!rst && out_valid && !out_stall) begin
      if (rate_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: divisor %0d fine_adjust %0d", divisor, fine_adjust);
      end else begin
        want = rate_q.pop_front();
        if (divisor !== want.div || fine_adjust !== want.fine) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: divisor exp %0d got %0d, fine_adjust exp %0d got %0d",
                     want.div, divisor, want.fine, fine_adjust);
        end
      end
    end
  end

  // Stimulus
  initial begin
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_BASE_CLOCK;
    cfg_data     = '0;
    in_valid     = 1'b0;
    port_number  = '0;
    baud_request = '0;

    dir_tab = '{
      // reset setting: fallback, limit edges, truncated divisors
      lit_row(0, 0, 6250, 0),
      lit_row(2, 0, 3125, 0),
      lit_row(0, 50_000_000, 0, 4),
      lit_row(1, 50_000_001, 6250, 0),
      lit_row(7, 32'hFFFF_FFFF, 3125, 0),
      lit_row(5, 50_000_000, 0, 2),
      req_row(0, 115_200),
      req_row(6, 9_600),
      req_row(3, 1),
      req_row(4, 32'h02AA_AAAA),
      lit_row(0, 32'h5555_5555, 6250, 0),
      req_row(1, 16),
      // zero base clock: everything falls back, quotients vanish
      cfg_row(CFG_BASE_CLOCK, '0),
      lit_row(0, 12_345, 0, 0),
      lit_row(7, 0, 0, 0),
      // zero fallback baud: fallback results forced to zero
      cfg_row(CFG_FALLBACK_BAUD, '0),
      lit_row(1, 0, 0, 0),
      cfg_row(CFG_BASE_CLOCK, '1),
      lit_row(0, 0, 0, 0),
      req_row(0, 1),
      lit_row(2, 134_217_727, 0, 2),
      lit_row(0, 134_217_728, 0, 0),
      cfg_row(CFG_FALLBACK_BAUD, 28'h3FF_FFFF),
      req_row(0, 0),
      // one-hertz clock: half-clock ports get zero, limit is zero
      cfg_row(CFG_BASE_CLOCK, 1),
      cfg_row(CFG_FALLBACK_BAUD, 1),
      lit_row(0, 0, 0, 2),
      lit_row(2, 0, 0, 0),
      lit_row(1, 1, 0, 2),
      cfg_row(CFG_BASE_CLOCK, CFG_DATA_W'(BASE_CLOCK_RESET)),
      cfg_row(CFG_FALLBACK_BAUD, CFG_DATA_W'(FALLBACK_RESET))
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        send_request(dir_tab[i].port, dir_tab[i].baud, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    pick_setting();
    run_phase(60);

    // long receiver hold with the sender pushing back-to-back until in_stall rises
    sender_gaps = 1'b0;
    hold_now    = 1'b1;
    run_phase(80);
    sender_gaps = 1'b1;

    for (int ph = 0; ph < 5; ph++) begin
      idle_odds = (ph % 2 == 1) ? 3 : 12;
      pick_setting();
      run_phase(50);
    end

    // last stretch runs flat out
    pick_setting();
    quiet = 1'b1;
    run_phase(50);

    if (cfg_valid) cfg_valid <= 1'b0;
    if (in_valid) in_valid <= 1'b0;
    wait (rate_q.size() == 0);
    repeat (PIPE_DEPTH + 10) @(posedge clk);
    if (mismatches == 0 && rate_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

[uart_baud_divisor_calc.f]
+incdir+rtl/core
rtl/core/ubdc_pkg.sv
rtl/core/ubdc_front.sv
rtl/core/ubdc_cell.sv
rtl/core/uart_baud_divisor_calc.sv
rtl/core/ubdc_checker.sv
tb/testbench.sv
